@@ rtl/vmu_pkg.sv @@
`timescale 1ns / 1ps

package vmu_pkg;

  localparam int unsigned ChunkBits   = 64;
  localparam int unsigned IdxBits     = 6;
  localparam int unsigned ActBits     = 7;
  localparam int unsigned CountBits   = 17;
  localparam int unsigned PosBits     = 16;
  localparam int unsigned ChunkNumBits = 10;
  localparam int unsigned XlenMax     = 64;

  typedef enum logic [3:0] {
    MODE_AND  = 4'd0,
    MODE_NAND = 4'd1,
    MODE_ANDN = 4'd2,
    MODE_OR   = 4'd3,
    MODE_NOR  = 4'd4,
    MODE_ORN  = 4'd5,
    MODE_XOR  = 4'd6,
    MODE_XNOR = 4'd7,
    MODE_CPOP = 4'd8,
    MODE_FIRST = 4'd9,
    MODE_SBF  = 4'd10,
    MODE_SIF  = 4'd11,
    MODE_SOF  = 4'd12
  } mode_e;

  typedef struct packed {
    logic [3:0]           mode;
    logic                 unmasked;
    logic [ChunkBits-1:0] src1_bits;
    logic [ChunkBits-1:0] src2_bits;
    logic [ChunkBits-1:0] mask_bits;
    logic [ChunkBits-1:0] dest_bits;
    logic [ActBits-1:0]   active_bits;
    logic                 first_chunk;
    logic                 last_chunk;
  } item_t;

  typedef struct packed {
    logic [ChunkBits-1:0] result_bits;
    logic [XlenMax-1:0]   scalar_value;
    logic                 scalar_valid;
    logic                 last_out;
  } result_t;

endpackage

@@ rtl/vmu_in_if.sv @@
`timescale 1ns / 1ps

interface vmu_in_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    mode;
  logic                          unmasked;
  logic [vmu_pkg::ChunkBits-1:0] src1_bits;
  logic [vmu_pkg::ChunkBits-1:0] src2_bits;
  logic [vmu_pkg::ChunkBits-1:0] mask_bits;
  logic [vmu_pkg::ChunkBits-1:0] dest_bits;
  logic [vmu_pkg::ActBits-1:0]   active_bits;
  logic                          first_chunk;
  logic                          last_chunk;

  modport source (
    output valid, mode, unmasked, src1_bits, src2_bits, mask_bits, dest_bits,
           active_bits, first_chunk, last_chunk,
    input  ready
  );

  modport sink (
    input  valid, mode, unmasked, src1_bits, src2_bits, mask_bits, dest_bits,
           active_bits, first_chunk, last_chunk,
    output ready
  );
endinterface

@@ rtl/vmu_out_if.sv @@
`timescale 1ns / 1ps

interface vmu_out_if;
  logic                          valid;
  logic                          ready;
  logic [vmu_pkg::ChunkBits-1:0] result_bits;
  logic [vmu_pkg::XlenMax-1:0]   scalar_value;
  logic                          scalar_valid;
  logic                          last_out;

  modport source (
    output valid, result_bits, scalar_value, scalar_valid, last_out,
    input  ready
  );

  modport sink (
    input  valid, result_bits, scalar_value, scalar_valid, last_out,
    output ready
  );
endinterface

@@ rtl/vector_mask_unit.sv @@
`timescale 1ns / 1ps

// path: an accepted request is held in the input register, then in the result
// register, where it stays while the result is not taken
// throughput: one request per cycle; input register and result register
// stall together only while a result waits and the input register is full
// reset: async active low, clears valids and running state, xlen64_q to 1
module vector_mask_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  vmu_in_if.sink            in_i,
  vmu_out_if.source         out_o
);

  localparam int unsigned CB = vmu_pkg::ChunkBits;

  logic                               xlen64_q;
  logic                               in_valid_q;
  vmu_pkg::item_t                     in_q;
  logic                               out_valid_q;
  vmu_pkg::result_t                   out_q;
  vmu_pkg::result_t                   out_d;

  logic                               found_q, found_d;
  logic [vmu_pkg::CountBits-1:0]      count_q, count_d;
  logic [vmu_pkg::PosBits-1:0]        pos_q, pos_d;
  logic [vmu_pkg::ChunkNumBits-1:0]   chunk_q, chunk_d;

  logic                               advance;
  logic                               in_fire;

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !in_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlen64_q <= 1'b1;
    end else if (cfg_we_i) begin
      xlen64_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.mode        <= in_i.mode;
      in_q.unmasked    <= in_i.unmasked;
      in_q.src1_bits   <= in_i.src1_bits;
      in_q.src2_bits   <= in_i.src2_bits;
      in_q.mask_bits   <= in_i.mask_bits;
      in_q.dest_bits   <= in_i.dest_bits;
      in_q.active_bits <= in_i.active_bits;
      in_q.first_chunk <= in_i.first_chunk;
      in_q.last_chunk  <= in_i.last_chunk;
    end
  end

  // chunk datapath
  logic                          f_eff;
  logic [vmu_pkg::CountBits-1:0] c_eff;
  logic [vmu_pkg::PosBits-1:0]   p_eff;
  logic [vmu_pkg::ChunkNumBits-1:0] n_eff;
  logic [CB-1:0]                 act, vmask, src, vs1, vs2, vd, newv, lowbit;
  logic [vmu_pkg::IdxBits:0]     pcnt;
  logic [vmu_pkg::IdxBits-1:0]   idx;
  logic                          any;
  logic [vmu_pkg::PosBits-1:0]   hit_pos;
  logic [vmu_pkg::XlenMax-1:0]   not_found;

  always_comb begin
    f_eff = in_q.first_chunk ? 1'b0 : found_q;
    c_eff = in_q.first_chunk ? '0 : count_q;
    p_eff = in_q.first_chunk ? '0 : pos_q;
    n_eff = in_q.first_chunk ? '0 : chunk_q;

    vs1 = in_q.src1_bits;
    vs2 = in_q.src2_bits;
    vd  = in_q.dest_bits;

    act   = in_q.active_bits[vmu_pkg::ActBits-1] ? '1
          : ((CB'(1) << in_q.active_bits[vmu_pkg::IdxBits-1:0]) - CB'(1));
    vmask = in_q.unmasked ? '1 : in_q.mask_bits;
    src   = vs2 & vmask & act;
    any   = |src;

    pcnt = '0;
    for (int i = 0; i < CB; i++) begin
      pcnt = pcnt + (vmu_pkg::IdxBits+1)'(src[i]);
    end

    idx = '0;
    for (int i = CB - 1; i >= 0; i--) begin
      if (src[i]) begin
        idx = vmu_pkg::IdxBits'(i);
      end
    end
    lowbit  = src & (~src + CB'(1));
    hit_pos = {n_eff, idx};

    not_found = xlen64_q ? '1 : {{(vmu_pkg::XlenMax-32){1'b0}}, {32{1'b1}}};

    found_d = f_eff;
    count_d = c_eff;
    pos_d   = p_eff;
    newv    = '0;

    out_d.result_bits  = vd;
    out_d.scalar_value = '0;
    out_d.scalar_valid = 1'b0;
    out_d.last_out     = in_q.last_chunk;

    case (vmu_pkg::mode_e'(in_q.mode))
      vmu_pkg::MODE_AND, vmu_pkg::MODE_NAND, vmu_pkg::MODE_ANDN,
      vmu_pkg::MODE_OR, vmu_pkg::MODE_NOR, vmu_pkg::MODE_ORN,
      vmu_pkg::MODE_XOR, vmu_pkg::MODE_XNOR: begin
        case (vmu_pkg::mode_e'(in_q.mode))
          vmu_pkg::MODE_AND:  newv = vs2 & vs1;
          vmu_pkg::MODE_NAND: newv = ~(vs2 & vs1);
          vmu_pkg::MODE_ANDN: newv = vs2 & ~vs1;
          vmu_pkg::MODE_OR:   newv = vs2 | vs1;
          vmu_pkg::MODE_NOR:  newv = ~(vs2 | vs1);
          vmu_pkg::MODE_ORN:  newv = vs2 | ~vs1;
          vmu_pkg::MODE_XOR:  newv = vs2 ^ vs1;
          default:            newv = ~(vs2 ^ vs1);
        endcase
        out_d.result_bits = (newv & act) | (vd & ~act);
      end
      vmu_pkg::MODE_CPOP: begin
        count_d = c_eff + vmu_pkg::CountBits'(pcnt);
        if (in_q.last_chunk) begin
          out_d.scalar_value = vmu_pkg::XlenMax'(count_d);
          out_d.scalar_valid = 1'b1;
        end
      end
      vmu_pkg::MODE_FIRST: begin
        if (!f_eff && any) begin
          found_d = 1'b1;
          pos_d   = hit_pos;
        end
        if (in_q.last_chunk) begin
          out_d.scalar_value = found_d ? vmu_pkg::XlenMax'(pos_d) : not_found;
          out_d.scalar_valid = 1'b1;
        end
      end
      vmu_pkg::MODE_SBF, vmu_pkg::MODE_SIF, vmu_pkg::MODE_SOF: begin
        if (f_eff) begin
          newv = '0;
        end else if (any) begin
          found_d = 1'b1;
          pos_d   = hit_pos;
          case (vmu_pkg::mode_e'(in_q.mode))
            vmu_pkg::MODE_SBF: newv = lowbit - CB'(1);
            vmu_pkg::MODE_SIF: newv = (lowbit - CB'(1)) | lowbit;
            default:           newv = lowbit;
          endcase
        end else begin
          newv = (vmu_pkg::mode_e'(in_q.mode) == vmu_pkg::MODE_SOF) ? '0 : '1;
        end
        newv = (vd & ~vmask) | (newv & vmask);
        out_d.result_bits = (newv & act) | (vd & ~act);
      end
      default: begin
        out_d.result_bits = vd;
      end
    endcase

    chunk_d = n_eff + vmu_pkg::ChunkNumBits'(1);
    if (in_q.last_chunk) begin
      found_d = 1'b0;
      count_d = '0;
      pos_d   = '0;
      chunk_d = '0;
    end
  end

  // running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      count_q <= '0;
      pos_q   <= '0;
      chunk_q <= '0;
    end else if (advance && in_valid_q) begin
      found_q <= found_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      chunk_q <= chunk_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_bits  = out_q.result_bits;
  assign out_o.scalar_value = out_q.scalar_value;
  assign out_o.scalar_valid = out_q.scalar_valid;
  assign out_o.last_out     = out_q.last_out;

endmodule

@@ rtl/vmu_chk.sv @@
`timescale 1ns / 1ps

module vmu_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [vmu_pkg::ChunkBits-1:0] result_bits_i,
  input logic [vmu_pkg::XlenMax-1:0]   scalar_value_i,
  input logic                          scalar_valid_i,
  input logic                          last_out_i
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_bits_i))
    else $error("stalled result dropped or changed");

  // scalar only on the last chunk
  a_scalar_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && scalar_valid_i |-> last_out_i)
    else $error("scalar result before last chunk");

  // no scalar value without its flag
  a_scalar_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !scalar_valid_i |-> scalar_value_i == '0)
    else $error("scalar value without scalar_valid");

  // input register free whenever the result side drains
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while output free");

  // accepted request moves on to the result register when the result side drains
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i ##1 (!out_valid_i || out_ready_i) |=> out_valid_i)
    else $error("accepted request produced no result");

endmodule

bind vector_mask_unit vmu_chk u_vmu_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_bits_i  (out_o.result_bits),
  .scalar_value_i (out_o.scalar_value),
  .scalar_valid_i (out_o.scalar_valid),
  .last_out_i     (out_o.last_out)
);
